[design/websocket_frame_deframer_macros.svh]
// Assertion macros shared by the frame deframer RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// Generic form: explicit clock and disable condition.
`define WSD_ASSERT_DIS(lbl, clk, dis, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) prop) else $error(msg);

// Usual form: block clock, disabled while reset is asserted.
`define WSD_ASSERT(lbl, prop, msg) \
  `WSD_ASSERT_DIS(lbl, clk_i, !rst_ni, prop, msg)

`endif

[design/wsd_pkg.sv]
// Shared types and constants of the WebSocket frame deframer.
// No dependencies; imported by the parser core and the top level.
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

  // Parser phase.
  typedef enum logic [1:0] {
    PhHeader  = 2'd0,
    PhPayload = 2'd1,
    PhErrBig  = 2'd2,
    PhErrOp   = 2'd3
  } wsd_phase_e;

  // Event reported with each result.
  typedef enum logic [1:0] {
    EvHeader     = 2'd0,
    EvHeaderDone = 2'd1,
    EvPayload    = 2'd2,
    EvError      = 2'd3
  } wsd_event_e;

  // Message kind being received.
  typedef enum logic [2:0] {
    KindNone   = 3'd0,
    KindText   = 3'd1,
    KindBinary = 3'd2,
    KindClose  = 3'd3,
    KindPing   = 3'd4,
    KindPong   = 3'd5
  } wsd_kind_e;

  // Error code reported while the parser is stuck in an error phase.
  typedef enum logic [1:0] {
    ErrNone    = 2'd0,
    ErrTooBig  = 2'd1,
    ErrOpcode  = 2'd2
  } wsd_err_e;

  // Frame opcodes.
  localparam logic [3:0] OpCont   = 4'h0;
  localparam logic [3:0] OpText   = 4'h1;
  localparam logic [3:0] OpBinary = 4'h2;
  localparam logic [3:0] OpClose  = 4'h8;
  localparam logic [3:0] OpPing   = 4'h9;
  localparam logic [3:0] OpPong   = 4'hA;

  // Length codes and header geometry.
  localparam logic [6:0] LenCode64    = 7'd127;
  localparam logic [6:0] LenCode16    = 7'd126;
  localparam logic [3:0] BaseHdrLen   = 4'd2;
  localparam logic [3:0] Ext16Len     = 4'd2;
  localparam logic [3:0] Ext64Len     = 4'd8;
  localparam logic [3:0] MaskKeyLen   = 4'd4;
  localparam logic [3:0] MaxHeaderLen = 4'd10;

  // One input request as seen by the parser core.
  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] data_byte;
  } wsd_item_t;

  // One result.
  typedef struct packed {
    wsd_event_e  event_res;
    logic [7:0]  payload_byte;
    logic        last_of_frame;
    wsd_kind_e   message_kind;
    logic [31:0] payload_length;
    logic [31:0] message_total;
    logic        fin_flag;
    logic        masked_flag;
    wsd_err_e    error_code;
  } wsd_result_t;

endpackage

`default_nettype wire

[design/wsd_in_if.sv]
// Input channel of the frame deframer: valid/ready with one received byte.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

`default_nettype wire

[design/wsd_out_if.sv]
// Result channel of the frame deframer: valid/ready with one parse result.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface wsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [7:0]  payload_byte;
  logic        last_of_frame;
  logic [2:0]  message_kind;
  logic [31:0] payload_length;
  logic [31:0] message_total;
  logic        fin_flag;
  logic        masked_flag;
  logic [1:0]  error_code;

  modport source (
    output valid, output event_res, output payload_byte, output last_of_frame,
    output message_kind, output payload_length, output message_total,
    output fin_flag, output masked_flag, output error_code, input ready
  );
  modport sink (
    input valid, input event_res, input payload_byte, input last_of_frame,
    input message_kind, input payload_length, input message_total,
    input fin_flag, input masked_flag, input error_code, output ready
  );
endinterface

`default_nettype wire

[design/websocket_frame_deframer.sv]
// WebSocket receive frame deframer: RFC 6455 header parse and payload unmask,
// one received byte per cycle while neither channel stalls. Takes one byte or
// restart request per clock when not stalled; each request yields exactly one
// result. A request passes an input register and then the result register
// before its result is presented. The sustained rate is one request per
// cycle while the result side takes every result. The parser state loop
// closes in the core between the input register and the result register.
// A header takes 2 to 14 bytes;
// a 64-bit length with any nonzero byte among its upper four bytes, or an
// unknown opcode, sends the parser into an error phase that answers every
// byte with an error result until a restart request. Both channels stall
// independently; the result register lets a new byte enter while a result
// waits to be taken.
// Depends on wsd_pkg, wsd_in_if, wsd_out_if, wsd_core and the macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "websocket_frame_deframer_macros.svh"

module websocket_frame_deframer
  import wsd_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  wsd_in_if.sink   in_i,
  wsd_out_if.source out_o
);

  logic        s1_valid_q;
  logic        s1_kind_q;
  logic [7:0]  s1_byte_q;
  logic        res_valid_q;
  wsd_result_t res_q;
  wsd_result_t core_res;
  wsd_item_t   core_item;
  logic        out_adv;
  logic        step;
  logic        in_acc;

  // Handshake control: the result register frees when empty or taken.
  assign out_adv    = !res_valid_q || out_o.ready;
  assign step       = s1_valid_q && out_adv;
  assign in_i.ready = !s1_valid_q || out_adv;
  assign in_acc     = in_i.valid && in_i.ready;

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (step) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q <= in_i.kind;
      s1_byte_q <= in_i.data_byte;
    end
  end

  // Parser core.
  assign core_item = '{valid: step, kind: s1_kind_q, data_byte: s1_byte_q};

  wsd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (core_item),
    .res_o  (core_res)
  );

  // Result register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_adv) begin
      res_valid_q <= s1_valid_q;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= core_res;
    end
  end

  // Output channel.
  assign out_o.valid          = res_valid_q;
  assign out_o.event_res      = res_q.event_res;
  assign out_o.payload_byte   = res_q.payload_byte;
  assign out_o.last_of_frame  = res_q.last_of_frame;
  assign out_o.message_kind   = res_q.message_kind;
  assign out_o.payload_length = res_q.payload_length;
  assign out_o.message_total  = res_q.message_total;
  assign out_o.fin_flag       = res_q.fin_flag;
  assign out_o.masked_flag    = res_q.masked_flag;
  assign out_o.error_code     = res_q.error_code;

  // A processed request always lands in the result register.
  `WSD_ASSERT(a_step_lands, step |=> res_valid_q, "processed request lost")
  // A request held in the input register waits while the result side stalls.
  `WSD_ASSERT(a_s1_hold, s1_valid_q && !out_adv |=> s1_valid_q && $stable(s1_byte_q), "input register changed while stalled")
  // A stalled result keeps its contents.
  `WSD_ASSERT(a_res_hold, res_valid_q && !out_o.ready |=> $stable(res_q), "result changed while stalled")

endmodule

`default_nettype wire

[design/wsd_core.sv]
// Parser core: frame header parse, message tracking and payload unmask.
// Depends on wsd_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "websocket_frame_deframer_macros.svh"

module wsd_core
  import wsd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire wsd_item_t   item_i,
  output      wsd_result_t res_o
);

  // Header bytes 2 to 5 of a 64-bit length must be zero.
  localparam logic [3:0] LongHiEnd = 4'd6;

  wsd_phase_e  phase_q, phase_d;
  logic [3:0]  hpos_q, hpos_d;
  logic [3:0]  hlen_q, hlen_d;
  logic [7:0]  fhb_q, fhb_d;
  logic [7:0]  lcode_q, lcode_d;
  logic [31:0] lacc_q, lacc_d;
  logic [31:0] mask_q, mask_d;
  logic [31:0] prem_q, prem_d;
  logic [1:0]  ppos_q, ppos_d;
  wsd_kind_e   ckind_q, ckind_d;
  logic [31:0] total_q, total_d;

  wsd_event_e  ev;
  logic [7:0]  pb;
  logic        last;
  logic [3:0]  ext_q;
  logic [3:0]  ext_b;
  logic [3:0]  key_pos;
  logic [7:0]  key;
  logic        op_ok;
  logic [7:0]  b;

  assign b = item_i.data_byte;

  // Extended length byte count from the stored and from the incoming length code.
  always_comb begin
    ext_q = (lcode_q[6:0] == LenCode64) ? Ext64Len :
            (lcode_q[6:0] == LenCode16) ? Ext16Len : 4'd0;
    ext_b = (b[6:0] == LenCode64) ? Ext64Len :
            (b[6:0] == LenCode16) ? Ext16Len : 4'd0;
    key_pos = hpos_q - BaseHdrLen - ext_q;
    key = lcode_q[7] ? mask_q[{ppos_q, 3'b000} +: 8] : 8'd0;
  end

  // Next state and result for the request at the core input.
  always_comb begin
    phase_d = phase_q;
    hpos_d  = hpos_q;
    hlen_d  = hlen_q;
    fhb_d   = fhb_q;
    lcode_d = lcode_q;
    lacc_d  = lacc_q;
    mask_d  = mask_q;
    prem_d  = prem_q;
    ppos_d  = ppos_q;
    ckind_d = ckind_q;
    total_d = total_q;
    ev      = EvHeader;
    pb      = 8'd0;
    last    = 1'b0;
    op_ok   = 1'b1;

    if (item_i.kind) begin
      // Restart: everything back to its reset value.
      phase_d = PhHeader;
      hpos_d  = 4'd0;
      hlen_d  = BaseHdrLen;
      fhb_d   = 8'd0;
      lcode_d = 8'd0;
      lacc_d  = 32'd0;
      mask_d  = 32'd0;
      prem_d  = 32'd0;
      ppos_d  = 2'd0;
      ckind_d = KindNone;
      total_d = 32'd0;
    end else begin
      unique case (phase_q)
        PhErrBig, PhErrOp: begin
          ev = EvError;
        end
        PhPayload: begin
          pb     = b ^ key;
          ev     = EvPayload;
          ppos_d = ppos_q + 2'd1;
          prem_d = prem_q - 32'd1;
          if (prem_d == 32'd0) begin
            last    = 1'b1;
            phase_d = PhHeader;
            hpos_d  = 4'd0;
            hlen_d  = BaseHdrLen;
          end
        end
        PhHeader: begin
          // Store the header byte according to its position.
          if (hpos_q == 4'd0) begin
            fhb_d = b;
          end else if (hpos_q == 4'd1) begin
            lcode_d = b;
            hlen_d  = BaseHdrLen + ext_b + (b[7] ? MaskKeyLen : 4'd0);
            lacc_d  = (ext_b == 4'd0) ? {25'd0, b[6:0]} : 32'd0;
            mask_d  = 32'd0;
          end else if (hpos_q < BaseHdrLen + ext_q) begin
            if (ext_q == Ext64Len && hpos_q < LongHiEnd && b != 8'd0) begin
              phase_d = PhErrBig;
              ckind_d = KindClose;
              total_d = 32'd0;
              ev      = EvError;
            end else begin
              lacc_d = {lacc_q[23:0], b};
            end
          end else begin
            for (int i = 0; i < 4; i++) begin
              if (key_pos[1:0] == 2'(i)) begin
                mask_d[i*8 +: 8] = b;
              end
            end
          end

          // Header completion: apply the opcode and choose the next phase.
          if (ev != EvError) begin
            hpos_d = hpos_q + 4'd1;
            if (hpos_q != 4'd0 && ({1'b0, hpos_q} + 5'd1) >= {1'b0, hlen_d}) begin
              unique case (fhb_d[3:0])
                OpCont: begin
                  total_d = (ckind_q == KindPing) ? lacc_d : total_q + lacc_d;
                end
                OpText: begin
                  ckind_d = KindText;
                  total_d = lacc_d;
                end
                OpBinary: begin
                  ckind_d = KindBinary;
                  total_d = lacc_d;
                end
                OpClose: begin
                  ckind_d = KindClose;
                  total_d = lacc_d;
                end
                OpPing: begin
                  ckind_d = KindPing;
                  total_d = lacc_d;
                end
                OpPong: begin
                  ckind_d = KindPong;
                  total_d = lacc_d;
                end
                default: begin
                  op_ok = 1'b0;
                end
              endcase
              if (!op_ok) begin
                phase_d = PhErrOp;
                ckind_d = KindClose;
                total_d = 32'd0;
                ev      = EvError;
              end else begin
                ev = EvHeaderDone;
                if (lacc_d == 32'd0) begin
                  last    = 1'b1;
                  phase_d = PhHeader;
                  hpos_d  = 4'd0;
                  hlen_d  = BaseHdrLen;
                end else begin
                  phase_d = PhPayload;
                  prem_d  = lacc_d;
                  ppos_d  = 2'd0;
                end
              end
            end
          end
        end
        default: begin
          ev = EvError;
        end
      endcase
    end
  end

  // Result fields reflect the state after this request.
  always_comb begin
    res_o.event_res      = ev;
    res_o.payload_byte   = pb;
    res_o.last_of_frame  = last;
    res_o.message_kind   = ckind_d;
    res_o.payload_length = lacc_d;
    res_o.message_total  = total_d;
    res_o.fin_flag       = fhb_d[7];
    res_o.masked_flag    = lcode_d[7];
    res_o.error_code     = (phase_d == PhErrBig) ? ErrTooBig :
                           (phase_d == PhErrOp)  ? ErrOpcode : ErrNone;
  end

  // Parser state, updated once per request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      hpos_q  <= 4'd0;
      hlen_q  <= BaseHdrLen;
      fhb_q   <= 8'd0;
      lcode_q <= 8'd0;
      lacc_q  <= 32'd0;
      mask_q  <= 32'd0;
      prem_q  <= 32'd0;
      ppos_q  <= 2'd0;
      ckind_q <= KindNone;
      total_q <= 32'd0;
    end else if (item_i.valid) begin
      phase_q <= phase_d;
      hpos_q  <= hpos_d;
      hlen_q  <= hlen_d;
      fhb_q   <= fhb_d;
      lcode_q <= lcode_d;
      lacc_q  <= lacc_d;
      mask_q  <= mask_d;
      prem_q  <= prem_d;
      ppos_q  <= ppos_d;
      ckind_q <= ckind_d;
      total_q <= total_d;
    end
  end

  // Header length never exceeds the longest header with a mask key.
  `WSD_ASSERT(a_hlen_bound, hlen_q <= MaxHeaderLen + MaskKeyLen, "header length out of range")
  // The payload phase always has bytes left to deliver.
  `WSD_ASSERT(a_payload_left, phase_q == PhPayload |-> prem_q != 32'd0, "empty payload phase")
  // An error phase is left only through a restart.
  `WSD_ASSERT(a_err_sticky, (phase_q == PhErrBig || phase_q == PhErrOp) && !(item_i.valid && item_i.kind) |=> phase_q == $past(phase_q), "error phase left without restart")
  // The message kind only takes defined codes.
  `WSD_ASSERT(a_kind_range, ckind_q <= KindPong, "message kind out of range")

endmodule

`default_nettype wire

[sim/tb_websocket_frame_deframer.sv]
// Self-checking testbench for the WebSocket receive frame deframer.
// A byte-level model of the header parser and unmasker predicts every result.
// Depends on wsd_pkg, wsd_in_if, wsd_out_if and websocket_frame_deframer.
`timescale 1ns / 1ps

module tb_websocket_frame_deframer;
  import wsd_pkg::*;

  // Length encodings that a generated frame header may use.
  typedef enum int {
    Len7,
    Len16,
    Len64
  } len_form_e;

  // The four length bytes of a 64-bit length that must stay zero.
  localparam logic [3:0] UpperLenEnd = BaseHdrLen + 4'd4;
  localparam int MaxPrinted = 200;

  // Model of the deframer plus the queue of results it still owes.
  class deframer_results;
    wsd_result_t results_due[$];
    int unsigned failures;
    int unsigned printed;

    wsd_phase_e  phase;
    logic [3:0]  hdr_pos;
    logic [3:0]  hdr_len;
    logic [7:0]  first_byte;
    logic [7:0]  len_code;
    logic [31:0] len_acc;
    logic [31:0] mask_key;
    logic [31:0] remaining;
    logic [1:0]  pay_pos;
    wsd_kind_e   cur_kind;
    logic [31:0] msg_total;

    function new();
      failures = 0;
      printed  = 0;
      clear_state();
    endfunction

    function void begin_header();
      phase   = PhHeader;
      hdr_pos = 4'd0;
      hdr_len = BaseHdrLen;
    endfunction

    function void clear_state();
      begin_header();
      first_byte = 8'h00;
      len_code   = 8'h00;
      len_acc    = 32'd0;
      mask_key   = 32'd0;
      remaining  = 32'd0;
      pay_pos    = 2'd0;
      cur_kind   = KindNone;
      msg_total  = 32'd0;
    endfunction

    function void enter_error(wsd_phase_e err_phase);
      phase     = err_phase;
      cur_kind  = KindClose;
      msg_total = 32'd0;
    endfunction

    function logic [3:0] ext_bytes(logic [6:0] code);
      if (code == LenCode64) return Ext64Len;
      if (code == LenCode16) return Ext16Len;
      return 4'd0;
    endfunction

    // Updates kind and running message length; returns 0 for an unknown opcode.
    function bit take_opcode(logic [3:0] op, logic [31:0] len);
      case (op)
        OpCont:   msg_total = (cur_kind == KindPing) ? len : msg_total + len;
        OpText:   begin cur_kind = KindText;   msg_total = len; end
        OpBinary: begin cur_kind = KindBinary; msg_total = len; end
        OpClose:  begin cur_kind = KindClose;  msg_total = len; end
        OpPing:   begin cur_kind = KindPing;   msg_total = len; end
        OpPong:   begin cur_kind = KindPong;   msg_total = len; end
        default:  return 1'b0;
      endcase
      return 1'b1;
    endfunction

    // Advances the model by one request and returns the result it causes.
    function wsd_result_t deframe_step(bit restart, logic [7:0] b);
      wsd_result_t r;
      logic [3:0]  pos;
      logic [3:0]  ext;
      logic [3:0]  slot;
      logic [7:0]  key_byte;
      r = '0;
      r.event_res = EvHeader;
      if (restart) begin
        clear_state();
      end else if (phase == PhErrBig || phase == PhErrOp) begin
        r.event_res = EvError;
      end else if (phase == PhPayload) begin
        key_byte = len_code[7] ? mask_key[8*pay_pos +: 8] : 8'h00;
        r.payload_byte = b ^ key_byte;
        r.event_res = EvPayload;
        pay_pos = pay_pos + 2'd1;
        remaining = remaining - 32'd1;
        if (remaining == 32'd0) begin
          r.last_of_frame = 1'b1;
          begin_header();
        end
      end else begin
        pos = hdr_pos;
        ext = ext_bytes(len_code[6:0]);
        if (pos == 4'd0) begin
          first_byte = b;
        end else if (pos == 4'd1) begin
          len_code = b;
          ext = ext_bytes(b[6:0]);
          hdr_len = BaseHdrLen + ext + (b[7] ? MaskKeyLen : 4'd0);
          len_acc = (ext == 4'd0) ? {25'd0, b[6:0]} : 32'd0;
          mask_key = 32'd0;
        end else if (pos < BaseHdrLen + ext) begin
          // Upper half of a 64-bit length must be zero.
          if (ext == Ext64Len && pos < UpperLenEnd && b != 8'h00) begin
            enter_error(PhErrBig);
            r.event_res = EvError;
          end else begin
            len_acc = {len_acc[23:0], b};
          end
        end else begin
          slot = pos - BaseHdrLen - ext;
          mask_key[8*slot[1:0] +: 8] = b;
        end

        // Header completion: apply the opcode and choose the next phase.
        if (r.event_res != EvError) begin
          hdr_pos = pos + 4'd1;
          if (pos >= 4'd1 && {1'b0, pos} + 5'd1 >= {1'b0, hdr_len}) begin
            if (!take_opcode(first_byte[3:0], len_acc)) begin
              enter_error(PhErrOp);
              r.event_res = EvError;
            end else begin
              r.event_res = EvHeaderDone;
              if (len_acc == 32'd0) begin
                r.last_of_frame = 1'b1;
                begin_header();
              end else begin
                phase = PhPayload;
                remaining = len_acc;
                pay_pos = 2'd0;
              end
            end
          end
        end
      end
      r.message_kind   = cur_kind;
      r.payload_length = len_acc;
      r.message_total  = msg_total;
      r.fin_flag       = first_byte[7];
      r.masked_flag    = len_code[7];
      r.error_code     = (phase == PhErrBig) ? ErrTooBig :
                         (phase == PhErrOp) ? ErrOpcode : ErrNone;
      return r;
    endfunction

    function void note_request(bit restart, logic [7:0] b);
      results_due.push_back(deframe_step(restart, b));
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    function void report(string msg);
      failures++;
      if (printed < MaxPrinted) begin
        printed++;
        $display("%0t: %s", $time, msg);
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen)
        report($sformatf("%s mismatch: expected 0x%0h, got 0x%0h", name, want, seen));
    endfunction

    function void check_result(wsd_result_t seen);
      wsd_result_t want;
      if (results_due.size() == 0) begin
        report($sformatf("result with no request outstanding: 0x%0h", seen));
        return;
      end
      want = results_due.pop_front();
      compare_field("event_res", 32'(want.event_res), 32'(seen.event_res));
      compare_field("payload_byte", 32'(want.payload_byte), 32'(seen.payload_byte));
      compare_field("last_of_frame", 32'(want.last_of_frame), 32'(seen.last_of_frame));
      compare_field("message_kind", 32'(want.message_kind), 32'(seen.message_kind));
      compare_field("payload_length", want.payload_length, seen.payload_length);
      compare_field("message_total", want.message_total, seen.message_total);
      compare_field("fin_flag", 32'(want.fin_flag), 32'(seen.fin_flag));
      compare_field("masked_flag", 32'(want.masked_flag), 32'(seen.masked_flag));
      compare_field("error_code", 32'(want.error_code), 32'(seen.error_code));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   steady_run = 1'b0;
  int   stream_bytes = 0;
  deframer_results results;
  wsd_result_t seen_result;

  wsd_in_if  in_if();
  wsd_out_if out_if();

  websocket_frame_deframer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watch both channels at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (in_if.valid && in_if.ready) results.note_request(in_if.kind, in_if.data_byte);
      if (out_if.valid && out_if.ready) begin
        seen_result.event_res      = wsd_event_e'(out_if.event_res);
        seen_result.payload_byte   = out_if.payload_byte;
        seen_result.last_of_frame  = out_if.last_of_frame;
        seen_result.message_kind   = wsd_kind_e'(out_if.message_kind);
        seen_result.payload_length = out_if.payload_length;
        seen_result.message_total  = out_if.message_total;
        seen_result.fin_flag       = out_if.fin_flag;
        seen_result.masked_flag    = out_if.masked_flag;
        seen_result.error_code     = wsd_err_e'(out_if.error_code);
        results.check_result(seen_result);
      end
    end
  end

  // Result side stalls in short random bursts until the final stretch.
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!steady_run && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  // Offers one request and waits for it to be taken; called at a falling edge.
  task automatic push_request(input bit restart, input logic [7:0] data);
    if (!steady_run && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.kind      <= restart;
    in_if.data_byte <= data;
    if (!restart) stream_bytes++;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  // Sends a frame header and the given number of payload bytes.
  task automatic send_frame(input bit fin, input logic [3:0] op, input bit masked,
                            input len_form_e form, input logic [31:0] len, input int body);
    logic [7:0] mark;
    mark = {masked, 7'd0};
    push_request(1'b0, {fin, 3'($urandom), op});
    case (form)
      Len7: push_request(1'b0, mark | {1'b0, len[6:0]});
      Len16: begin
        push_request(1'b0, mark | {1'b0, LenCode16});
        push_request(1'b0, len[15:8]);
        push_request(1'b0, len[7:0]);
      end
      default: begin
        push_request(1'b0, mark | {1'b0, LenCode64});
        repeat (4) push_request(1'b0, 8'h00);
        for (int i = 3; i >= 0; i--) push_request(1'b0, len[8*i +: 8]);
      end
    endcase
    if (masked) repeat (4) push_request(1'b0, 8'($urandom));
    repeat (body) push_request(1'b0, 8'($urandom));
  endtask

  // 64-bit length header with a nonzero byte at one of the upper positions.
  task automatic send_oversize(input int bad_pos, input logic [7:0] bad_val);
    push_request(1'b0, {1'($urandom), 3'($urandom), OpBinary});
    push_request(1'b0, {1'($urandom), LenCode64});
    for (int p = 2; p <= bad_pos; p++) push_request(1'b0, (p == bad_pos) ? bad_val : 8'h00);
  endtask

  // Bytes dropped in the error phase do not count as stimulus.
  task automatic drop_then_restart(input int count);
    repeat (count) push_request(1'b0, 8'($urandom));
    stream_bytes -= count;
    push_request(1'b1, 8'($urandom));
  endtask

  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (results.pending() != 0) @(negedge clk_i);
  endtask

  // Run limit.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    bit          fin;
    bit          masked;
    logic [3:0]  op;
    logic [31:0] len;
    len_form_e   form;
    int          roll;
    int          next_drain;

    results = new();
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind = 1'b0;
    in_if.data_byte = 8'h00;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: every opcode, each length form, the extreme lengths and errors.
    push_request(1'b1, 8'hA5);
    send_frame(1'b1, OpText, 1'b0, Len7, 32'd3, 3);
    send_frame(1'b0, OpText, 1'b1, Len7, 32'd5, 5);
    send_frame(1'b1, OpCont, 1'b1, Len7, 32'd2, 2);
    send_frame(1'b1, OpBinary, 1'b1, Len7, 32'd0, 0);
    send_frame(1'b1, OpClose, 1'b0, Len7, 32'd0, 0);
    send_frame(1'b1, OpPing, 1'b1, Len7, 32'd1, 1);
    // A continuation after a ping restarts the message length.
    send_frame(1'b1, OpCont, 1'b0, Len7, 32'd2, 2);
    send_frame(1'b1, OpPong, 1'b0, Len16, 32'd5, 5);
    send_frame(1'b0, OpBinary, 1'b1, Len64, 32'd4, 4);
    send_frame(1'b1, OpText, 1'b1, Len7, 32'd125, 125);
    send_frame(1'b1, OpBinary, 1'b1, Len64, 32'hFFFF_FFFF, 3);
    push_request(1'b1, 8'hFF);
    send_frame(1'b0, OpText, 1'b0, Len16, 32'h0000_FFFF, 2);
    push_request(1'b1, 8'h00);
    send_oversize(2, 8'h80);
    drop_then_restart(2);
    send_oversize(5, 8'h01);
    drop_then_restart(1);
    send_frame(1'b1, 4'h3, 1'b0, Len7, 32'd2, 0);
    drop_then_restart(2);
    send_frame(1'b0, 4'hF, 1'b1, Len7, 32'd0, 0);
    drop_then_restart(1);
    // Restart in the middle of a header.
    push_request(1'b0, 8'h81);
    push_request(1'b1, 8'h00);
    hold_until_drained();

    // Random part: mostly well-formed frames, some broken ones and noise.
    next_drain = 150;
    while (stream_bytes < 500) begin
      if (stream_bytes >= 420) steady_run = 1'b1;
      fin = 1'($urandom);
      masked = 1'($urandom);
      case ($urandom_range(0, 5))
        0: op = OpCont;
        1: op = OpText;
        2: op = OpBinary;
        3: op = OpClose;
        4: op = OpPing;
        default: op = OpPong;
      endcase
      roll = $urandom_range(0, 9);
      form = (roll < 7) ? Len7 : (roll < 9) ? Len16 : Len64;
      if ($urandom_range(0, 9) == 0)
        len = (form == Len7) ? $urandom_range(0, 125) : $urandom_range(0, 300);
      else
        len = $urandom_range(0, 12);

      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        send_frame(fin, op, masked, form, len, len);
      end else if (roll < 78) begin
        // Frame cut short by a restart.
        if (len == 0) len = 1;
        send_frame(fin, op, masked, form, len, $urandom_range(0, len - 1));
        push_request(1'b1, 8'($urandom));
      end else if (roll < 84) begin
        do op = 4'($urandom); while (op inside {OpCont, OpText, OpBinary, OpClose,
                                                OpPing, OpPong});
        send_frame(fin, op, masked, form, len, 0);
        drop_then_restart($urandom_range(0, 3));
      end else if (roll < 90) begin
        send_oversize($urandom_range(2, 5), 8'($urandom_range(1, 255)));
        drop_then_restart($urandom_range(0, 3));
      end else if (roll < 96) begin
        repeat ($urandom_range(1, 12)) push_request(1'b0, 8'($urandom));
        push_request(1'b1, 8'($urandom));
      end else begin
        push_request(1'b1, 8'($urandom));
      end

      if (stream_bytes >= next_drain) begin
        hold_until_drained();
        next_drain += 150;
      end
    end

    // Wait for the last results, then keep watching for strays.
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    for (int i = 0; i < 2000 && results.pending() != 0; i++) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (results.pending() != 0)
      results.report($sformatf("%0d expected results never arrived", results.pending()));
    if (results.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/wsd_pkg.sv
design/wsd_in_if.sv
design/wsd_out_if.sv
design/wsd_core.sv
design/websocket_frame_deframer.sv
sim/tb_websocket_frame_deframer.sv
